### rtl/cnfsa_pkg.sv
// cnfsa_pkg: shared constants, result codes and scan types for the
// circular next-free-slot allocator. No dependencies.
package cnfsa_pkg;

    // field and register widths
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int SPOTS_DEF = 1024;

    // occupancy memory word geometry
    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;
    localparam int WIDX_W = COUNT_W - OFF_W;

    // result codes
    localparam logic [STATUS_W-1:0] GS_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] GS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] GS_RANGE   = 2'd2;

    // how a word is looked at during the search
    typedef struct packed {
        logic             first_visit;  // start word, slots at or after the start
        logic             final_visit;  // start word again, slots before the start
        logic             last_word;    // word holding the highest slot in use
        logic [OFF_W-1:0] start_off;    // bit of the start slot in its word
        logic [OFF_W-1:0] last_off;     // bit of the highest slot in use
    } scan_ctl_t;

    typedef struct packed {
        logic              found;
        logic [OFF_W-1:0]  bit_pos;
        logic [WORD_W-1:0] new_word;
    } scan_res_t;

endpackage

### rtl/circular_next_free_slot_allocator.sv
// circular_next_free_slot_allocator: top level, request control and
// occupancy memory. Depends on cnfsa_pkg, cnfsa_ram and cnfsa_scan.
//
// Occupancy lives in a ram of ceil(SPOTS/32) words of 32 slots each. After
// reset a clearing pass writes one word a cycle over every word, before the
// first request is taken; spot_count writes are taken throughout. An
// accepted request reads the wanted slot's word and scans each word read:
// a free slot found is written back marked taken, else the next word is
// read, wrapping after the highest word in use, until the start word is
// seen again for the slots before the wanted one; a wanted slot out of
// range skips the search. The ram read is registered, once per word
// visited. One result follows each request, held in an output register so
// the next request can be taken while it waits.
module circular_next_free_slot_allocator #(
    parameter int SPOTS = cnfsa_pkg::SPOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cnfsa_pkg::COUNT_W-1:0]   cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cnfsa_pkg::COUNT_W-1:0]   wanted_spot,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cnfsa_pkg::COUNT_W-1:0]   granted_spot,
    output logic [cnfsa_pkg::STATUS_W-1:0]  grant_status
);
    import cnfsa_pkg::*;

    localparam int WORDS  = (SPOTS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [31:0] SPOTS_U = 32'(SPOTS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [COUNT_W-1:0]    spot_count_reg;
    logic [WIDX_W-1:0]     cur_word_reg;
    logic [WIDX_W-1:0]     start_word_reg;
    logic [OFF_W-1:0]      start_off_reg;
    logic                  first_reg;
    logic [COUNT_W-1:0]    res_spot_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    granted_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [COUNT_W-1:0]    eff_n;
    logic [COUNT_W-1:0]    n_minus1;
    logic [WIDX_W-1:0]     last_word;
    logic [COUNT_W-1:0]    wanted_m1;
    logic                  out_of_range;
    logic                  in_xact;
    logic                  final_visit;
    logic [WIDX_W-1:0]     next_word;
    logic                  out_free;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    scan_ctl_t             scan_ctl;
    scan_res_t             scan_res;

    // effective count, saturated to the capacity
    assign eff_n = (32'(spot_count_reg) > SPOTS_U) ? SPOTS_U[COUNT_W-1:0] : spot_count_reg;
    assign n_minus1  = eff_n - COUNT_W'(1);
    assign last_word = n_minus1[COUNT_W-1:OFF_W];

    // request decode
    assign wanted_m1    = wanted_spot - COUNT_W'(1);
    assign out_of_range = (wanted_spot == '0) || (wanted_spot > eff_n);
    assign in_ready     = (state_reg == S_IDLE);
    assign in_xact      = in_valid && in_ready;

    // search walk
    assign final_visit = (cur_word_reg == start_word_reg) && !first_reg;
    assign next_word   = (cur_word_reg == last_word) ? '0 : cur_word_reg + WIDX_W'(1);

    assign scan_ctl.first_visit = first_reg;
    assign scan_ctl.final_visit = final_visit;
    assign scan_ctl.last_word   = (cur_word_reg == last_word);
    assign scan_ctl.start_off   = start_off_reg;
    assign scan_ctl.last_off    = n_minus1[OFF_W-1:0];

    cnfsa_scan u_scan (
        .word_data (ram_rdata),
        .ctl       (scan_ctl),
        .res       (scan_res)
    );

    // ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(wanted_m1[COUNT_W-1:OFF_W]);
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                ram_re = in_xact && !out_of_range;
            end
            S_SEARCH:
            begin
                if (scan_res.found)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(cur_word_reg);
                    ram_wdata = scan_res.new_word;
                end
                else if (!final_visit)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(next_word);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    cnfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_count_reg <= COUNT_W'(1024);
        end
        else if (cfg_we)
        begin
            spot_count_reg <= cfg_wdata;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // request state machine and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            // the response state reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_xact)
                    begin
                        if (out_of_range)
                        begin
                            res_spot_reg   <= '0;
                            res_status_reg <= GS_RANGE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            start_word_reg <= wanted_m1[COUNT_W-1:OFF_W];
                            cur_word_reg   <= wanted_m1[COUNT_W-1:OFF_W];
                            start_off_reg  <= wanted_m1[OFF_W-1:0];
                            first_reg      <= 1'b1;
                            state_reg      <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (scan_res.found)
                    begin
                        res_spot_reg   <= {cur_word_reg, scan_res.bit_pos} + COUNT_W'(1);
                        res_status_reg <= GS_GRANTED;
                        state_reg      <= S_RESP;
                    end
                    else if (final_visit)
                    begin
                        res_spot_reg   <= '0;
                        res_status_reg <= GS_FULL;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        cur_word_reg <= next_word;
                        first_reg    <= 1'b0;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        granted_reg   <= res_spot_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_spot = granted_reg;
    assign grant_status = status_reg;

    // a grant names a slot within the count in use
    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && grant_status == GS_GRANTED) |->
        (granted_spot != '0 && granted_spot <= eff_n))
        else $error("grant outside the slots in use");

    // a refused transaction carries slot zero
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && grant_status != GS_GRANTED) |-> (granted_spot == '0))
        else $error("refused transaction carries a slot");

    // an accepted transaction leaves the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> (state_reg == S_SEARCH || state_reg == S_RESP))
        else $error("accepted transaction not taken up");

    // the walk never leaves the words in use
    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (cur_word_reg <= last_word))
        else $error("search word beyond the count in use");

endmodule

### rtl/cnfsa_ram.sv
// cnfsa_ram: generic single-port-write, single-port-read ram with a
// registered read. No dependencies.
module cnfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/cnfsa_scan.sv
// cnfsa_scan: masks one occupancy word to the slots eligible on this visit,
// finds the lowest free one and builds the word with it marked taken.
// Depends on cnfsa_pkg.
module cnfsa_scan (
    input  logic [cnfsa_pkg::WORD_W-1:0] word_data,
    input  cnfsa_pkg::scan_ctl_t         ctl,
    output cnfsa_pkg::scan_res_t         res
);
    import cnfsa_pkg::*;

    logic [WORD_W-1:0] ones;
    logic [WORD_W-1:0] limit_mask;
    logic [WORD_W-1:0] start_mask;
    logic [WORD_W-1:0] free_bits;
    logic [OFF_W-1:0]  pos;

    assign ones = '1;

    // slots above the count in use are never eligible
    assign limit_mask = ctl.last_word ? (ones >> (~ctl.last_off)) : ones;

    // first visit: at or after the start; final visit: before the start
    always_comb
    begin
        if (ctl.final_visit)
        begin
            start_mask = ~(ones << ctl.start_off);
        end
        else if (ctl.first_visit)
        begin
            start_mask = ones << ctl.start_off;
        end
        else
        begin
            start_mask = ones;
        end
    end

    assign free_bits = ~word_data & limit_mask & start_mask;

    // lowest free slot
    always_comb
    begin
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = OFF_W'(i);
            end
        end
    end

    assign res.found    = |free_bits;
    assign res.bit_pos  = pos;
    assign res.new_word = word_data | (WORD_W'(1) << pos);

endmodule
